/* hdl/forbidden_zone_hit_check_macros.svh */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FORBIDDEN_ZONE_HIT_CHECK_MACROS_SVH
`define FORBIDDEN_ZONE_HIT_CHECK_MACROS_SVH

// same-cycle implication
`define FZHC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication
`define FZHC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* hdl/fzhc_pkg.sv */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: package
// Field widths, MAC widths, operand/destination codes and the edge microprogram.
// ----------------------------------------------------------------------------
package fzhc_pkg;

	localparam int COORD_BITS  = 20;
	localparam int MARGIN_BITS = 20;
	localparam int ZCOUNT_BITS = 5;
	localparam int INDEX_BITS  = 4;

	localparam int OP_W   = 24;           // multiplier operand
	localparam int PROD_W = 2 * OP_W;
	localparam int CHUNK  = 22;           // split width of wide operands
	localparam int WIDE_W = 2 * CHUNK;    // len2, |cross|, margin^2
	localparam int ACC_W  = 92;

	localparam int EDGE_OPS = 22;
	localparam int STEP_W   = 5;

	typedef logic [3:0] sel_t;
	typedef logic [3:0] dst_t;

	localparam sel_t SEL_EX = 4'd0;   // px - xi
	localparam sel_t SEL_EY = 4'd1;   // py - yi
	localparam sel_t SEL_WX = 4'd2;   // px - xj
	localparam sel_t SEL_WY = 4'd3;   // py - yj
	localparam sel_t SEL_DX = 4'd4;   // xi - xj
	localparam sel_t SEL_DY = 4'd5;   // yi - yj
	localparam sel_t SEL_M  = 4'd6;
	localparam sel_t SEL_ML = 4'd7;
	localparam sel_t SEL_MH = 4'd8;
	localparam sel_t SEL_LL = 4'd9;
	localparam sel_t SEL_LH = 4'd10;
	localparam sel_t SEL_CL = 4'd11;
	localparam sel_t SEL_CH = 4'd12;

	localparam dst_t DST_NONE  = 4'd0;
	localparam dst_t DST_RAY   = 4'd1;
	localparam dst_t DST_LEN   = 4'd2;
	localparam dst_t DST_DOT   = 4'd3;
	localparam dst_t DST_D0    = 4'd4;
	localparam dst_t DST_D1    = 4'd5;
	localparam dst_t DST_CROSS = 4'd6;
	localparam dst_t DST_PERP  = 4'd7;
	localparam dst_t DST_M2    = 4'd8;

	localparam logic [1:0] SH_0 = 2'd0;
	localparam logic [1:0] SH_1 = 2'd1;   // << CHUNK
	localparam logic [1:0] SH_2 = 2'd2;   // << 2*CHUNK

	typedef struct packed {
		sel_t       a_sel;
		sel_t       b_sel;
		logic       clr;
		logic       neg;
		logic [1:0] sh;
		dst_t       dst;
	} mop_t;

	typedef struct packed {
		logic       en;
		logic       clr;
		logic       neg;
		logic [1:0] sh;
		dst_t       dst;
	} mac_ctl_t;

	function automatic mop_t mk(sel_t a, sel_t b, logic c, logic n, logic [1:0] s, dst_t d);
		mop_t m;
		m.a_sel = a;
		m.b_sel = b;
		m.clr   = c;
		m.neg   = n;
		m.sh    = s;
		m.dst   = d;
		return m;
	endfunction

	// one edge: j = previous corner (segment start), i = current corner
	function automatic mop_t edge_op(logic [STEP_W-1:0] step);
		mop_t m;
		unique case (step)
			5'd0:    m = mk(SEL_EX, SEL_DY, 1'b1, 1'b1, SH_0, DST_NONE);
			5'd1:    m = mk(SEL_DX, SEL_EY, 1'b0, 1'b0, SH_0, DST_RAY);
			5'd2:    m = mk(SEL_DX, SEL_DX, 1'b1, 1'b0, SH_0, DST_NONE);
			5'd3:    m = mk(SEL_DY, SEL_DY, 1'b0, 1'b0, SH_0, DST_LEN);
			5'd4:    m = mk(SEL_WX, SEL_DX, 1'b1, 1'b0, SH_0, DST_NONE);
			5'd5:    m = mk(SEL_WY, SEL_DY, 1'b0, 1'b0, SH_0, DST_DOT);
			5'd6:    m = mk(SEL_WX, SEL_WX, 1'b1, 1'b0, SH_0, DST_NONE);
			5'd7:    m = mk(SEL_WY, SEL_WY, 1'b0, 1'b0, SH_0, DST_NONE);
			5'd8:    m = mk(SEL_M,  SEL_M,  1'b0, 1'b1, SH_0, DST_D0);
			5'd9:    m = mk(SEL_EX, SEL_EX, 1'b1, 1'b0, SH_0, DST_NONE);
			5'd10:   m = mk(SEL_EY, SEL_EY, 1'b0, 1'b0, SH_0, DST_NONE);
			5'd11:   m = mk(SEL_M,  SEL_M,  1'b0, 1'b1, SH_0, DST_D1);
			5'd12:   m = mk(SEL_WX, SEL_DY, 1'b1, 1'b0, SH_0, DST_NONE);
			5'd13:   m = mk(SEL_WY, SEL_DX, 1'b0, 1'b1, SH_0, DST_CROSS);
			// margin^2 * len2, subtracted; cross chunks not yet ready here
			5'd14:   m = mk(SEL_ML, SEL_LL, 1'b1, 1'b1, SH_0, DST_NONE);
			5'd15:   m = mk(SEL_ML, SEL_LH, 1'b0, 1'b1, SH_1, DST_NONE);
			5'd16:   m = mk(SEL_MH, SEL_LL, 1'b0, 1'b1, SH_1, DST_NONE);
			5'd17:   m = mk(SEL_MH, SEL_LH, 1'b0, 1'b1, SH_2, DST_NONE);
			5'd18:   m = mk(SEL_CL, SEL_CL, 1'b0, 1'b0, SH_0, DST_NONE);
			5'd19:   m = mk(SEL_CL, SEL_CH, 1'b0, 1'b0, SH_1, DST_NONE);
			5'd20:   m = mk(SEL_CL, SEL_CH, 1'b0, 1'b0, SH_1, DST_NONE);
			5'd21:   m = mk(SEL_CH, SEL_CH, 1'b0, 1'b0, SH_2, DST_PERP);
			default: m = mk(SEL_M,  SEL_M,  1'b0, 1'b0, SH_0, DST_NONE);
		endcase
		return m;
	endfunction

endpackage

/* hdl/fzhc_if.sv */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: channel interfaces
// Request channel (vertex write or point query) and result channel.
// ----------------------------------------------------------------------------
interface fzhc_req_if;
	import fzhc_pkg::*;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [3:0]                    zone_sel;
	logic [1:0]                    vertex_sel;
	logic signed [COORD_BITS-1:0]  coord_x;
	logic signed [COORD_BITS-1:0]  coord_y;
	logic                          use_margin;
	logic [MARGIN_BITS-1:0]        margin;

	modport source (output valid, req_type, zone_sel, vertex_sel, coord_x, coord_y,
		use_margin, margin, input ready);
	modport sink (input valid, req_type, zone_sel, vertex_sel, coord_x, coord_y,
		use_margin, margin, output ready);
endinterface

interface fzhc_res_if;
	import fzhc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  hit;
	logic [INDEX_BITS-1:0] zone_index;

	modport source (output valid, hit, zone_index, input ready);
	modport sink (input valid, hit, zone_index, output ready);
endinterface

/* hdl/fzhc_ram.sv */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fzhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/fzhc_mac.sv */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: shared multiply-accumulate unit
// Registered 24x24 signed product, then a shifted add/subtract into a wide
// accumulator. The next accumulator value is exported with its destination tag.
// ----------------------------------------------------------------------------
module fzhc_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fzhc_pkg::mac_ctl_t                ctl,
	input  logic signed [fzhc_pkg::OP_W-1:0]  op_a,
	input  logic signed [fzhc_pkg::OP_W-1:0]  op_b,
	output logic signed [fzhc_pkg::ACC_W-1:0] acc_nxt,
	output fzhc_pkg::dst_t                    dst
);
	import fzhc_pkg::*;

	logic signed [PROD_W-1:0] p_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  base;

	always_ff @(posedge clk) begin
		p_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_comb begin
		unique case (ctl_s1.sh)
			SH_0:    term = ACC_W'(p_s1);
			SH_1:    term = ACC_W'(p_s1) <<< CHUNK;
			SH_2:    term = ACC_W'(p_s1) <<< (2 * CHUNK);
			default: term = '0;
		endcase
		base    = ctl_s1.clr ? '0 : acc_q;
		acc_nxt = ctl_s1.neg ? base - term : base + term;
		dst     = ctl_s1.en ? ctl_s1.dst : DST_NONE;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			acc_q <= acc_nxt;
		end
	end
endmodule

/* hdl/forbidden_zone_hit_check.sv */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: top level
// Vertex store plus a sequencer that walks zones and edges through one MAC.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | req_type, zone_sel, vertex_sel, coord_x, coord_y, use_margin, margin
//  res     | out | hit, zone_index (one per query, none per vertex write)
//  cfg     | in  | cfg_we, cfg_wdata = zone_count
//
// Vertex write: taken while idle. Query: zones are tested in order until the first
// hit, each edge by 22 MAC ops then pipeline drain and decision; with no active
// zone the query goes straight to the result.
// req.ready is high only when idle; the result is held until res.ready.
// Reset clears control state only; the vertex store is undefined until written.
// ----------------------------------------------------------------------------
`include "forbidden_zone_hit_check_macros.svh"

module forbidden_zone_hit_check #(
	parameter int ZONES         = 16,
	parameter int ZONE_VERTICES = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fzhc_pkg::ZCOUNT_BITS-1:0] cfg_wdata,
	fzhc_req_if.sink                         req,
	fzhc_res_if.source                       res
);
	import fzhc_pkg::*;

	localparam int DEPTH   = ZONES * ZONE_VERTICES;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VIDX_W  = $clog2(ZONE_VERTICES);
	localparam int ZCNT_W  = $clog2(ZONES + 1);
	localparam int ACT_W   = (ZCNT_W > ZCOUNT_BITS) ? ZCNT_W : ZCOUNT_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_LWAIT = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_EVAL  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]               state_q;
	logic [ZCOUNT_BITS-1:0]   zcnt_q;
	logic [ACT_W-1:0]         act;
	logic [ACT_W-1:0]         zone_q;
	logic [VIDX_W-1:0]        vidx_q;
	logic [STEP_W-1:0]        step_q;
	logic                     hit_q;
	logic [INDEX_BITS-1:0]    zidx_q;
	logic                     inside_q;
	logic                     near_q;

	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic                         use_m_q;
	logic [MARGIN_BITS-1:0]       margin_q;
	logic signed [COORD_BITS-1:0] vx_q [ZONE_VERTICES];
	logic signed [COORD_BITS-1:0] vy_q [ZONE_VERTICES];

	logic                     rd_v_s1;
	logic [VIDX_W-1:0]        rd_idx_s1;

	logic                     ray_neg_q, ray_pos_q;
	logic [WIDE_W-1:0]        len_q;
	logic signed [WIDE_W:0]   dot_q;
	logic                     d0_le_q, d1_le_q, perp_le_q;
	logic [WIDE_W-1:0]        cross_q;
	logic [WIDE_W-1:0]        m2_q;

	logic                     req_acc, wr_ok;
	logic [AW-1:0]            waddr, raddr;
	logic [2*COORD_BITS-1:0]  rdata;

	mop_t                     mop;
	mac_ctl_t                 ctl;
	logic signed [OP_W-1:0]   op_a, op_b;
	logic signed [ACC_W-1:0]  acc_nxt;
	logic signed [ACC_W-1:0]  acc_neg;
	dst_t                     dst;

	logic [VIDX_W-1:0]        ei, ej;
	logic signed [OP_W-1:0]   xi, yi, xj, yj, pxe, pye;
	logic signed [OP_W-1:0]   s_ex, s_ey, s_wx, s_wy, s_dx, s_dy, s_m;
	logic                     cross_hit, near_e, inside_n, near_n, zone_hit;
	logic                     last_edge, last_zone;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign res.valid  = (state_q == ST_OUT);
	assign res.hit    = hit_q;
	assign res.zone_index = zidx_q;

	assign act = (ACT_W'(zcnt_q) > ACT_W'(ZONES)) ? ACT_W'(ZONES) : ACT_W'(zcnt_q);

	// vertex store
	assign wr_ok = req_acc && !req.req_type && (int'(req.zone_sel) < ZONES)
		&& (int'(req.vertex_sel) < ZONE_VERTICES);
	assign waddr = AW'(int'(req.zone_sel) * ZONE_VERTICES + int'(req.vertex_sel));
	assign raddr = AW'(int'(zone_q) * ZONE_VERTICES + int'(vidx_q));

	fzhc_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (wr_ok),
		.waddr(waddr),
		.wdata({req.coord_y, req.coord_x}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// operand selection
	always_comb begin
		ei  = vidx_q;
		ej  = (vidx_q == '0) ? VIDX_W'(ZONE_VERTICES - 1) : vidx_q - 1'b1;
		xi  = OP_W'(vx_q[ei]);
		yi  = OP_W'(vy_q[ei]);
		xj  = OP_W'(vx_q[ej]);
		yj  = OP_W'(vy_q[ej]);
		pxe = OP_W'(px_q);
		pye = OP_W'(py_q);
		s_ex = pxe - xi;
		s_ey = pye - yi;
		s_wx = pxe - xj;
		s_wy = pye - yj;
		s_dx = xi - xj;
		s_dy = yi - yj;
		s_m  = $signed({{(OP_W - MARGIN_BITS){1'b0}}, margin_q});
	end

	function automatic logic signed [OP_W-1:0] pick(sel_t s,
		logic signed [OP_W-1:0] ex, logic signed [OP_W-1:0] ey,
		logic signed [OP_W-1:0] wx, logic signed [OP_W-1:0] wy,
		logic signed [OP_W-1:0] dx, logic signed [OP_W-1:0] dy,
		logic signed [OP_W-1:0] m, logic [WIDE_W-1:0] m2,
		logic [WIDE_W-1:0] ln, logic [WIDE_W-1:0] cr);
		logic signed [OP_W-1:0] r;
		unique case (s)
			SEL_EX:  r = ex;
			SEL_EY:  r = ey;
			SEL_WX:  r = wx;
			SEL_WY:  r = wy;
			SEL_DX:  r = dx;
			SEL_DY:  r = dy;
			SEL_M:   r = m;
			SEL_ML:  r = $signed({2'b00, m2[CHUNK-1:0]});
			SEL_MH:  r = $signed({2'b00, m2[WIDE_W-1:CHUNK]});
			SEL_LL:  r = $signed({2'b00, ln[CHUNK-1:0]});
			SEL_LH:  r = $signed({2'b00, ln[WIDE_W-1:CHUNK]});
			SEL_CL:  r = $signed({2'b00, cr[CHUNK-1:0]});
			SEL_CH:  r = $signed({2'b00, cr[WIDE_W-1:CHUNK]});
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		if (state_q == ST_SETUP) begin
			mop = mk(SEL_M, SEL_M, 1'b1, 1'b0, SH_0, DST_M2);
		end else begin
			mop = edge_op(step_q);
		end
		ctl.en  = (state_q == ST_SETUP) || (state_q == ST_RUN);
		ctl.clr = mop.clr;
		ctl.neg = mop.neg;
		ctl.sh  = mop.sh;
		ctl.dst = mop.dst;
		op_a = pick(mop.a_sel, s_ex, s_ey, s_wx, s_wy, s_dx, s_dy, s_m, m2_q, len_q, cross_q);
		op_b = pick(mop.b_sel, s_ex, s_ey, s_wx, s_wy, s_dx, s_dy, s_m, m2_q, len_q, cross_q);
	end

	fzhc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc_nxt(acc_nxt),
		.dst    (dst)
	);

	assign acc_neg = -acc_nxt;

	// result capture
	always_ff @(posedge clk) begin
		unique case (dst)
			DST_RAY: begin
				ray_neg_q <= acc_nxt < 0;
				ray_pos_q <= acc_nxt > 0;
			end
			DST_LEN:   len_q     <= acc_nxt[WIDE_W-1:0];
			DST_DOT:   dot_q     <= acc_nxt[WIDE_W:0];
			DST_D0:    d0_le_q   <= acc_nxt <= 0;
			DST_D1:    d1_le_q   <= acc_nxt <= 0;
			DST_CROSS: cross_q   <= (acc_nxt < 0) ? acc_neg[WIDE_W-1:0] : acc_nxt[WIDE_W-1:0];
			DST_PERP:  perp_le_q <= acc_nxt <= 0;
			DST_M2:    m2_q      <= acc_nxt[WIDE_W-1:0];
			default: begin
			end
		endcase
	end

	// vertex fetch
	always_ff @(posedge clk) begin
		rd_idx_s1 <= vidx_q;
		if (rd_v_s1) begin
			vx_q[rd_idx_s1] <= $signed(rdata[COORD_BITS-1:0]);
			vy_q[rd_idx_s1] <= $signed(rdata[2*COORD_BITS-1:COORD_BITS]);
		end
		if (req_acc) begin
			px_q     <= req.coord_x;
			py_q     <= req.coord_y;
			use_m_q  <= req.use_margin;
			margin_q <= req.margin;
		end
	end

	// per-edge decision
	always_comb begin
		cross_hit = ((vy_q[ei] > py_q) != (vy_q[ej] > py_q))
			&& ((vy_q[ej] > vy_q[ei]) ? ray_neg_q : ray_pos_q);
		priority if (len_q == '0) begin
			near_e = d0_le_q;
		end else if (dot_q <= 0) begin
			near_e = d0_le_q;
		end else if (dot_q >= $signed({1'b0, len_q})) begin
			near_e = d1_le_q;
		end else begin
			near_e = perp_le_q;
		end
		inside_n  = inside_q ^ cross_hit;
		near_n    = near_q | near_e;
		zone_hit  = inside_n | (use_m_q & near_n);
		last_edge = (vidx_q == VIDX_W'(ZONE_VERTICES - 1));
		last_zone = (zone_q + 1'b1 >= act);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			zcnt_q   <= '0;
			zone_q   <= '0;
			vidx_q   <= '0;
			step_q   <= '0;
			hit_q    <= 1'b0;
			zidx_q   <= '0;
			inside_q <= 1'b0;
			near_q   <= 1'b0;
			rd_v_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				zcnt_q <= cfg_wdata;
			end
			rd_v_s1 <= (state_q == ST_LOAD);
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && req.req_type) begin
						hit_q  <= 1'b0;
						zidx_q <= '0;
						zone_q <= '0;
						state_q <= (act == '0) ? ST_OUT : ST_SETUP;
					end
				end
				ST_SETUP: begin
					vidx_q   <= '0;
					inside_q <= 1'b0;
					near_q   <= 1'b0;
					state_q  <= ST_LOAD;
				end
				ST_LOAD: begin
					if (last_edge) begin
						vidx_q  <= '0;
						state_q <= ST_LWAIT;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				ST_LWAIT: begin
					step_q  <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step_q == STEP_W'(EDGE_OPS - 1)) begin
						state_q <= ST_DRAIN;
					end
					step_q <= step_q + 1'b1;
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					step_q <= '0;
					if (!last_edge) begin
						inside_q <= inside_n;
						near_q   <= near_n;
						vidx_q   <= vidx_q + 1'b1;
						state_q  <= ST_RUN;
					end else if (zone_hit) begin
						hit_q   <= 1'b1;
						zidx_q  <= zone_q[INDEX_BITS-1:0];
						state_q <= ST_OUT;
					end else if (last_zone) begin
						state_q <= ST_OUT;
					end else begin
						zone_q   <= zone_q + 1'b1;
						vidx_q   <= '0;
						inside_q <= 1'b0;
						near_q   <= 1'b0;
						state_q  <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FZHC_ASSERT_IMP(a_ready_no_result, req.ready, !res.valid)
	`FZHC_ASSERT_IMP(a_nohit_index_zero, res.valid && !res.hit, res.zone_index == '0)
	`FZHC_ASSERT_NXT(a_drain_to_eval, state_q == ST_DRAIN, state_q == ST_EVAL)
	`FZHC_ASSERT_IMP(a_step_range, state_q == ST_RUN, step_q < STEP_W'(EDGE_OPS))

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Forbidden zone hit check: testbench
// Loads zone corners and queries points against them. Checks each hit or miss
// result against a cycle-free geofence predictor. Random stalls are applied
// on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import fzhc_pkg::*;

	localparam int NZ = 16;
	localparam int NV = 4;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam int CRUISE = 110;   // idle cycles covering one zone walk

	typedef struct {
		logic                  hit;
		logic [INDEX_BITS-1:0] zone_index;
	} hit_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ZCOUNT_BITS-1:0] cfg_wdata;

	fzhc_req_if req ();
	fzhc_res_if res ();

	forbidden_zone_hit_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.res       (res.source)
	);

	// mirror of the vertex store and the zone count
	logic signed [COORD_BITS-1:0] corner_x [NZ][NV];
	logic signed [COORD_BITS-1:0] corner_y [NZ][NV];
	logic [ZCOUNT_BITS-1:0]       active_zones;
	// rough placement of each zone, used to aim queries
	int zone_cx [NZ];
	int zone_cy [NZ];
	int zone_sz [NZ];

	hit_t pending_hits [$];
	int   mismatches;
	int   calm_left;
	int   res_stall;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic bit seg_within(longint px, longint py, longint ax, longint ay,
			longint bx, longint by, longint m2);
		longint dx, dy, wx, wy, len2, dot, cr;
		logic signed [127:0] c2, lim;
		dx = bx - ax;
		dy = by - ay;
		wx = px - ax;
		wy = py - ay;
		len2 = dx * dx + dy * dy;
		if (len2 == 0)
			return wx * wx + wy * wy <= m2;
		dot = wx * dx + wy * dy;
		if (dot <= 0)
			return wx * wx + wy * wy <= m2;
		if (dot >= len2)
			return (px - bx) * (px - bx) + (py - by) * (py - by) <= m2;
		cr = wx * dy - wy * dx;
		c2 = cr;
		c2 = c2 * c2;
		lim = m2;
		lim = lim * len2;
		return c2 <= lim;
	endfunction

	function automatic bit zone_contains(int z, longint px, longint py, bit um, longint m2);
		bit in_zone;
		int j;
		longint xi, yi, xj, yj, d, lhs, rhs;
		in_zone = 1'b0;
		for (int i = 0; i < NV; i++) begin
			j = (i == 0) ? NV - 1 : i - 1;
			xi = corner_x[z][i];
			yi = corner_y[z][i];
			xj = corner_x[z][j];
			yj = corner_y[z][j];
			if ((yi > py) != (yj > py)) begin
				d = yj - yi;
				lhs = (px - xi) * d;
				rhs = (xj - xi) * (py - yi);
				if (d > 0 ? lhs < rhs : lhs > rhs)
					in_zone = !in_zone;
			end
		end
		if (in_zone)
			return 1'b1;
		if (!um)
			return 1'b0;
		for (int i = 0; i < NV; i++) begin
			j = (i == 0) ? NV - 1 : i - 1;
			if (seg_within(px, py, corner_x[z][j], corner_y[z][j],
					corner_x[z][i], corner_y[z][i], m2))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic hit_t first_zone_hit(logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y, logic um, logic [MARGIN_BITS-1:0] mg);
		hit_t r;
		int n;
		longint m2;
		r.hit = 1'b0;
		r.zone_index = '0;
		n = (active_zones > NZ) ? NZ : active_zones;
		m2 = longint'(mg) * longint'(mg);
		for (int z = 0; z < n; z++) begin
			if (zone_contains(z, x, y, um, m2)) begin
				r.hit = 1'b1;
				r.zone_index = z[INDEX_BITS-1:0];
				break;
			end
		end
		return r;
	endfunction

	function automatic int gap_cycles();
		if (calm_left > 0)
			return 0;
		if ($urandom_range(0, 3) != 0)
			return 0;
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	// one transaction on the request channel; prediction at acceptance
	task automatic send(logic t, logic [3:0] zs, logic [1:0] vs,
			logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
			logic um, logic [MARGIN_BITS-1:0] mg);
		int g;
		@(negedge clk);
		req.valid      = 1'b1;
		req.req_type   = t;
		req.zone_sel   = zs;
		req.vertex_sel = vs;
		req.coord_x    = x;
		req.coord_y    = y;
		req.use_margin = um;
		req.margin     = mg;
		do
			@(posedge clk);
		while (!req.ready);
		if (t == REQ_WRITE) begin
			corner_x[zs][vs] = x;
			corner_y[zs][vs] = y;
		end else begin
			pending_hits.insert(pending_hits.size(), first_zone_hit(x, y, um, mg));
		end
		g = gap_cycles();
		if (g > 0) begin
			@(negedge clk);
			req.valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_zone_count(logic [ZCOUNT_BITS-1:0] n);
		drain();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = n;
		active_zones = n;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic query(int x, int y, logic um, logic [MARGIN_BITS-1:0] mg);
		send(REQ_QUERY, 4'($urandom), 2'($urandom), x[COORD_BITS-1:0], y[COORD_BITS-1:0],
			um, mg);
	endtask

	task automatic put_zone(int z, int x0, int y0, int x1, int y1, int x2, int y2,
			int x3, int y3);
		send(REQ_WRITE, z[3:0], 2'd0, x0[19:0], y0[19:0], 1'($urandom),
			MARGIN_BITS'($urandom));
		send(REQ_WRITE, z[3:0], 2'd1, x1[19:0], y1[19:0], 1'($urandom),
			MARGIN_BITS'($urandom));
		send(REQ_WRITE, z[3:0], 2'd2, x2[19:0], y2[19:0], 1'($urandom),
			MARGIN_BITS'($urandom));
		send(REQ_WRITE, z[3:0], 2'd3, x3[19:0], y3[19:0], 1'($urandom),
			MARGIN_BITS'($urandom));
	endtask

	// random zone shape: mostly jittered quads, some degenerate or wild
	task automatic random_zone(int z);
		int cx, cy, s, j, kind;
		kind = $urandom_range(0, 19);
		s  = ($urandom_range(0, 7) == 0) ? $urandom_range(2000, 100000)
			: $urandom_range(4, 2000);
		cx = $signed($urandom_range(0, 800000)) - 400000;
		cy = $signed($urandom_range(0, 800000)) - 400000;
		j  = s / 3 + 1;
		zone_cx[z] = cx;
		zone_cy[z] = cy;
		zone_sz[z] = s;
		if (kind == 0)
			put_zone(z, cx, cy, cx, cy, cx, cy, cx, cy);
		else if (kind == 1)
			put_zone(z, cx - s, cy, cx, cy, cx + s, cy, cx, cy);
		else if (kind == 2)
			put_zone(z, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		else if (kind < 11)
			put_zone(z, cx - s + $urandom_range(0, j), cy - s + $urandom_range(0, j),
				cx + s - $urandom_range(0, j), cy - s + $urandom_range(0, j),
				cx + s - $urandom_range(0, j), cy + s - $urandom_range(0, j),
				cx - s + $urandom_range(0, j), cy + s - $urandom_range(0, j));
		else
			put_zone(z, cx - s, cy + s - $urandom_range(0, j),
				cx + s - $urandom_range(0, j), cy + s,
				cx + s, cy - s + $urandom_range(0, j),
				cx - s + $urandom_range(0, j), cy - s);
	endtask

	task automatic aimed_query();
		int z, s, x, y;
		logic [MARGIN_BITS-1:0] mg;
		z = $urandom_range(0, NZ - 1);
		s = zone_sz[z];
		x = zone_cx[z] + $signed($urandom_range(0, 3 * s)) - (3 * s) / 2;
		y = zone_cy[z] + $signed($urandom_range(0, 3 * s)) - (3 * s) / 2;
		mg = ($urandom_range(0, 9) == 0) ? MARGIN_BITS'($urandom)
			: MARGIN_BITS'($urandom_range(0, s));
		if ($urandom_range(0, 9) == 0)
			query($urandom, $urandom, 1'($urandom), mg);
		else
			query(x, y, $urandom_range(0, 2) != 0, mg);
	endtask

	task automatic test_load_zones();
		// a 100 by 100 square in zone 0, a zone spanning the full coordinate range in 1, the rest random
		put_zone(0, 0, 0, 100, 0, 100, 100, 0, 100);
		zone_cx[0] = 50;
		zone_cy[0] = 50;
		zone_sz[0] = 50;
		put_zone(1, -524288, -524288, 524287, -524288, 524287, 524287, -524288, 524287);
		zone_cx[1] = 0;
		zone_cy[1] = 0;
		zone_sz[1] = 100000;
		for (int z = 2; z < NZ; z++)
			random_zone(z);
	endtask

	task automatic test_directed();
		set_zone_count(5'd0);
		query(50, 50, 1'b1, 20'hFFFFF);
		set_zone_count(5'd1);
		query(50, 50, 1'b0, 20'd0);      // inside
		query(150, 50, 1'b0, 20'd100);   // outside, no margin
		query(150, 50, 1'b1, 20'd49);    // just beyond margin
		query(150, 50, 1'b1, 20'd50);    // on margin, perpendicular
		query(103, 104, 1'b1, 20'd5);    // corner end point
		query(-3, -4, 1'b1, 20'd4);
		query(0, 0, 1'b0, 20'd0);        // on a vertex
		query(100, 50, 1'b0, 20'd0);     // on right edge
		query(-524288, 524287, 1'b1, 20'hFFFFF);
		set_zone_count(5'd16);
		query(524287, -524288, 1'b0, 20'd0);
		query(-524288, -524288, 1'b1, 20'd0);
		query(200, 200, 1'b0, 20'd0);
		set_zone_count(5'd31);           // clamps to all zones
		query(-1, -1, 1'b1, 20'd1);
		// degenerate zone: a single point
		put_zone(2, 300, 300, 300, 300, 300, 300, 300, 300);
		set_zone_count(5'd3);
		query(303, 304, 1'b1, 20'd5);
		query(303, 304, 1'b1, 20'd4);
		query(600, 600, 1'b1, 20'd424);
		query(600, 600, 1'b1, 20'd425);
	endtask

	task automatic test_random();
		int n;
		for (int ph = 0; ph < 10; ph++) begin
			n = $urandom_range(0, 9);
			if (n == 0)
				set_zone_count(5'd0);
			else if (n == 1)
				set_zone_count(5'd16);
			else if (n == 2)
				set_zone_count(ZCOUNT_BITS'($urandom_range(17, 31)));
			else
				set_zone_count(ZCOUNT_BITS'($urandom_range(1, 8)));
			for (int k = 0; k < 70; k++) begin
				if ($urandom_range(0, 11) == 0)
					random_zone($urandom_range(0, NZ - 1));
				else
					aimed_query();
				if (ph == 4 && k == 40)
					drain();   // hold the sender until all results are back
			end
		end
	endtask

	// result side: random stalls with calm stretches
	always @(negedge clk) begin
		if (calm_left > 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(0, 499) == 0)
			calm_left <= $urandom_range(50, 300);
		if (res_stall > 0) begin
			res.ready <= 1'b0;
			res_stall <= res_stall - 1;
		end else begin
			res.ready <= 1'b1;
			if (calm_left == 0 && $urandom_range(0, 5) == 0)
				res_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
					: $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_hits.size() == 0) begin
				$error("unexpected result transaction hit=%0d zone_index=%0d",
					res.hit, res.zone_index);
				mismatches++;
			end else begin
				e = pending_hits.pop_front();
				if (res.hit !== e.hit) begin
					$error("hit expected %0d actual %0d", e.hit, res.hit);
					mismatches++;
				end
				if (res.zone_index !== e.zone_index) begin
					$error("zone_index expected %0d actual %0d", e.zone_index,
						res.zone_index);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#200000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		mismatches     = 0;
		calm_left      = 0;
		res_stall      = 0;
		active_zones   = '0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		res.ready      = 1'b0;
		req.valid      = 1'b0;
		req.req_type   = REQ_WRITE;
		req.zone_sel   = '0;
		req.vertex_sel = '0;
		req.coord_x    = '0;
		req.coord_y    = '0;
		req.use_margin = 1'b0;
		req.margin     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_load_zones();
		test_directed();
		test_random();
		drain();
		repeat (CRUISE) @(posedge clk);
		if (pending_hits.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
